### design/lgi_pkg.sv
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared types and constants of the lidar occupancy grid with obstacle
// inflation: item and result structs, register indexes, fixed point constants.
// ----------------------------------------------------------------------------
package lgi_pkg;

    localparam int GRID_COLS_DEF = 512;
    localparam int GRID_ROWS_DEF = 256;
    localparam int MAX_BEAMS_DEF = 4096;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd5;

    localparam logic [1:0] FUNC_POSE = 2'd0;
    localparam logic [1:0] FUNC_BEAM = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam int PI_Q20       = 3294199;
    localparam int HALF_PI_Q20  = 1647099;
    localparam int TWO_PI_Q20   = 6588397;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int CORDIC_STEPS = 20;
    localparam int RED_TOP      = 12;
    localparam int CELL_LIMIT   = 100000;

    localparam logic [23:0] RST_ORIGIN_X   = 24'd950272;
    localparam logic [23:0] RST_ORIGIN_Y   = 24'd45875;
    localparam logic [19:0] RST_MOUNT      = 20'd19186;
    localparam logic [23:0] RST_SCAN_START = 24'hDA6667;
    localparam logic [20:0] RST_BEAM_STEP  = 21'd6106;
    localparam logic [3:0]  RST_RADIUS     = 4'd6;

    typedef struct packed {
        logic [1:0]          func;
        logic signed [31:0]  pose_x;
        logic signed [31:0]  pose_y;
        logic signed [23:0]  pose_heading;
        logic [11:0]         beam_index;
        logic [23:0]         beam_range;
        logic                range_valid;
        logic [8:0]          query_x;
        logic [7:0]          query_y;
    } t_item;

    typedef struct packed {
        logic        cell_free;
        logic [16:0] hit_cell_x;
        logic [16:0] hit_cell_y;
        logic        marked_any;
    } t_result;

    function automatic logic signed [23:0] atan_q20(input logic [4:0] i);
        logic signed [23:0] v;
        unique case (i)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

### design/lgi_ram.sv
// ----------------------------------------------------------------------------
// lgi_ram
// Simple dual port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lgi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/lidar_occupancy_grid_inflate.sv
// ----------------------------------------------------------------------------
// lidar_occupancy_grid_inflate
// Occupancy bit grid fed by lidar beams; each hit marks a square of cells.
// ----------------------------------------------------------------------------
// Usage: raise i_start with an item on i_item while o_busy is low. Each item
// gives one result on o_result, marked by o_valid for one cycle; the receiver
// cannot stall it. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata while the block is idle.
// Steps: pose, invalid beam and unused codes answer in the cycle after
// accept; a cell read goes through S_QRY first. A marking beam runs two
// sine/cosine passes on one shared CORDIC unit (13 reduction steps, 1 fold,
// 20 rotations each), then a multiply and accumulate phase on one shared
// multiplier, cell and clip math, and for each marked row a read, modify,
// write back on the row memory. Items are handled one at a time. For a
// cell read or marking beam o_busy stays high until the result is out.
// The grid is a memory of GRID_ROWS rows of GRID_COLS bits. After reset a
// clearing pass writes every row free, one row a cycle; o_busy is high
// meanwhile.
// ----------------------------------------------------------------------------
module lidar_occupancy_grid_inflate #(
    parameter int GRID_COLS = lgi_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = lgi_pkg::GRID_ROWS_DEF,
    parameter int MAX_BEAMS = lgi_pkg::MAX_BEAMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  lgi_pkg::t_item                  i_item,
    output logic                            o_busy,
    output logic                            o_valid,
    output lgi_pkg::t_result                o_result,
    input  logic                            i_cfg_we,
    input  logic [lgi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lgi_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import lgi_pkg::*;

    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam logic [17:0] COL_MAX  = 18'(GRID_COLS - 1);
    localparam logic [17:0] ROW_MAX  = 18'(GRID_ROWS - 1);
    localparam logic [12:0] COLS13   = 13'(GRID_COLS);
    localparam logic [12:0] ROWS13   = 13'(GRID_ROWS);
    localparam logic [16:0] BEAM_LIM = 17'(MAX_BEAMS);

    localparam logic [35:0]        TWO_PI36 = 36'(TWO_PI_Q20);
    localparam logic signed [24:0] PI_S     = 25'(PI_Q20);
    localparam logic signed [24:0] HALF_S   = 25'(HALF_PI_Q20);
    localparam logic signed [24:0] TWO_PI_S = 25'(TWO_PI_Q20);
    localparam logic signed [32:0] GAIN_S   = 33'(CORDIC_GAIN);
    localparam logic [4:0]         ROT_LAST = 5'(CORDIC_STEPS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_QRY   = 4'd2;
    localparam logic [3:0] S_RED   = 4'd3;
    localparam logic [3:0] S_FOLD  = 4'd4;
    localparam logic [3:0] S_ROT   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_CELL  = 4'd7;
    localparam logic [3:0] S_CLIP  = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_MWR   = 4'd10;

    // control
    logic [3:0]  r_state, n_state;
    logic [17:0] r_row, n_row;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_which, n_which;
    logic        r_out_valid, n_out_valid;
    logic [23:0] r_org_x, r_org_y, r_scan;
    logic [19:0] r_mount;
    logic [20:0] r_step;
    logic [3:0]  r_rad;
    logic signed [31:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [23:0] r_sh, n_sh;

    // payload
    t_result            r_out, n_out;
    logic signed [35:0] r_ang, n_ang;
    logic [35:0]        r_red, n_red;
    logic [23:0]        r_range, n_range;
    logic signed [23:0] r_z, n_z;
    logic               r_neg, n_neg;
    logic signed [32:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [32:0] r_hc, n_hc, r_hs, n_hs, r_bc, n_bc, r_bs, n_bs;
    logic signed [57:0] r_prod, n_prod;
    logic signed [34:0] r_accx, n_accx, r_accy, n_accy;
    logic [16:0]        r_hcx, n_hcx, r_hcy, n_hcy;
    logic [17:0]        r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    logic [8:0]         r_qx, n_qx;
    logic               r_qok, n_qok;

    // memory
    logic                 mem_we;
    logic [ROW_W-1:0]     mem_waddr, mem_raddr;
    logic [GRID_COLS-1:0] mem_wdata, mem_rdata, row_mask;

    lgi_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    function automatic logic [35:0] red_init(input logic signed [35:0] a);
        logic signed [35:0] s;
        s = (a < 0) ? a + 36'sd26353588 : a;
        return $unsigned(s);
    endfunction

    function automatic logic [16:0] to_cell(input logic signed [34:0] v);
        logic signed [39:0] r;
        logic [39:0]        c;
        logic [16:0]        res;
        r = (40'(v) <<< 4) + (40'(v) <<< 2);
        c = ($unsigned(r) + 40'd32768) >> 16;
        if (r < 0) begin
            res = '0;
        end else if (c > 40'(CELL_LIMIT)) begin
            res = '0;
        end else begin
            res = c[16:0];
        end
        return res;
    endfunction

    always_comb begin
        for (int i = 0; i < GRID_COLS; i++) begin
            row_mask[i] = (18'(i) >= r_x0) && (18'(i) <= r_x1);
        end
    end

    // datapath helpers
    logic [32:0]        ang_prod;
    logic signed [35:0] ang_in;
    logic [12:0]        qx13, qy13, rqx13;
    logic [35:0]        red_sub;
    logic signed [24:0] fr;
    logic signed [32:0] xs, ys, nx, ny;
    logic signed [23:0] at;
    logic signed [24:0] mlen;
    logic signed [32:0] mtrig;
    logic signed [57:0] mround;
    logic signed [34:0] madd;
    logic [17:0]        cx18, cy18, rad18, sx1, sy1;

    assign ang_prod = r_step * i_item.beam_index;
    assign ang_in   = 36'($signed(r_scan)) + $signed({3'b0, ang_prod}) + 36'(r_sh);
    assign qx13     = {4'b0, i_item.query_x};
    assign qy13     = {5'b0, i_item.query_y};
    assign rqx13    = {4'b0, r_qx};
    assign red_sub  = TWO_PI36 << r_cnt;
    assign xs       = r_cx >>> r_cnt;
    assign ys       = r_cy >>> r_cnt;
    assign at       = atan_q20(r_cnt);
    assign nx       = (r_z >= 0) ? r_cx - ys : r_cx + ys;
    assign ny       = (r_z >= 0) ? r_cy + xs : r_cy - xs;
    assign mlen     = r_cnt[2] ? $signed({1'b0, r_range}) : $signed({5'b0, r_mount});
    assign mround   = r_prod + 58'sd536870912;
    assign madd     = {{7{mround[57]}}, mround[57:30]};
    assign rad18    = {14'b0, r_rad};
    assign cx18     = {1'b0, r_hcx};
    assign cy18     = {1'b0, r_hcy};
    assign sx1      = cx18 + rad18;
    assign sy1      = cy18 + rad18;

    always_comb begin
        unique case (r_cnt[2:1])
            2'd0:    mtrig = r_hc;
            2'd1:    mtrig = r_hs;
            2'd2:    mtrig = r_bc;
            default: mtrig = r_bs;
        endcase
    end

    always_comb begin
        fr = $signed({1'b0, r_red[23:0]});
        n_neg = r_neg;
        if (r_state == S_FOLD) begin
            if (fr > PI_S) begin
                fr = fr - TWO_PI_S;
            end
            n_neg = 1'b0;
            if (fr > HALF_S) begin
                fr = fr - PI_S;
                n_neg = 1'b1;
            end else if (fr < -HALF_S) begin
                fr = fr + PI_S;
                n_neg = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;  n_row = r_row;  n_cnt = r_cnt;  n_which = r_which;
        n_out_valid = 1'b0; n_out = r_out;
        n_sx = r_sx; n_sy = r_sy; n_sh = r_sh;
        n_ang = r_ang; n_red = r_red; n_range = r_range; n_z = r_z;
        n_cx = r_cx; n_cy = r_cy;
        n_hc = r_hc; n_hs = r_hs; n_bc = r_bc; n_bs = r_bs;
        n_prod = r_prod; n_accx = r_accx; n_accy = r_accy;
        n_hcx = r_hcx; n_hcy = r_hcy;
        n_x0 = r_x0; n_x1 = r_x1; n_y0 = r_y0; n_y1 = r_y1;
        n_qx = r_qx; n_qok = r_qok;
        mem_we    = 1'b0;
        mem_wdata = '1;
        mem_waddr = r_row[ROW_W-1:0];
        mem_raddr = r_row[ROW_W-1:0];

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_row == ROW_MAX) begin
                    n_state = S_IDLE;
                    n_row   = '0;
                end else begin
                    n_row = r_row + 18'd1;
                end
            end
            S_IDLE: begin
                mem_raddr = qy13[ROW_W-1:0];
                if (i_start) begin
                    n_out = '0;
                    unique case (i_item.func)
                        FUNC_POSE: begin
                            n_sx = i_item.pose_x;
                            n_sy = i_item.pose_y;
                            n_sh = i_item.pose_heading;
                            n_out_valid = 1'b1;
                        end
                        FUNC_BEAM: begin
                            if (i_item.range_valid &&
                                ({5'b0, i_item.beam_index} < BEAM_LIM)) begin
                                n_ang   = ang_in;
                                n_range = i_item.beam_range;
                                n_red   = red_init(36'(r_sh));
                                n_which = 1'b0;
                                n_cnt   = 5'(RED_TOP);
                                n_state = S_RED;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        FUNC_READ: begin
                            n_qx    = i_item.query_x;
                            n_qok   = (qx13 < COLS13) && (qy13 < ROWS13);
                            n_state = S_QRY;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_QRY: begin
                n_out.cell_free = r_qok & mem_rdata[rqx13[COL_W-1:0]];
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            S_RED: begin
                // restoring reduction, 2*pi times a power of two a step
                if (r_red >= red_sub) begin
                    n_red = r_red - red_sub;
                end
                if (r_cnt == 5'd0) begin
                    n_state = S_FOLD;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_FOLD: begin
                n_z     = fr[23:0];
                n_cx    = GAIN_S;
                n_cy    = '0;
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                n_cx = nx;
                n_cy = ny;
                n_z  = (r_z >= 0) ? r_z - at : r_z + at;
                if (r_cnt == ROT_LAST) begin
                    if (!r_which) begin
                        n_hc    = r_neg ? -nx : nx;
                        n_hs    = r_neg ? -ny : ny;
                        n_which = 1'b1;
                        n_red   = red_init(r_ang);
                        n_cnt   = 5'(RED_TOP);
                        n_state = S_RED;
                    end else begin
                        n_bc    = r_neg ? -nx : nx;
                        n_bs    = r_neg ? -ny : ny;
                        n_accx  = 35'(r_sx) + $signed({11'b0, r_org_x});
                        n_accy  = 35'(r_sy) + $signed({11'b0, r_org_y});
                        n_cnt   = '0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_MUL: begin
                // even cycle multiplies, odd cycle rounds and accumulates
                if (!r_cnt[0]) begin
                    n_prod = mlen * mtrig;
                end else if (!r_cnt[1]) begin
                    n_accx = r_accx + madd;
                end else begin
                    n_accy = r_accy + madd;
                end
                if (r_cnt == 5'd7) begin
                    n_state = S_CELL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_CELL: begin
                n_hcx   = to_cell(r_accx);
                n_hcy   = to_cell(r_accy);
                n_state = S_CLIP;
            end
            S_CLIP: begin
                n_x0  = (cx18 > rad18) ? cx18 - rad18 : '0;
                n_x1  = (sx1 > COL_MAX) ? COL_MAX : sx1;
                n_y0  = (cy18 > rad18) ? cy18 - rad18 : '0;
                n_y1  = (sy1 > ROW_MAX) ? ROW_MAX : sy1;
                n_row = n_y0;
                n_out.cell_free  = 1'b0;
                n_out.hit_cell_x = r_hcx;
                n_out.hit_cell_y = r_hcy;
                n_out.marked_any = 1'b0;
                if ((n_x0 <= n_x1) && (n_y0 <= n_y1)) begin
                    n_state = S_MRD;
                end else begin
                    n_out_valid = 1'b1;
                    n_row       = '0;
                    n_state     = S_IDLE;
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~row_mask;
                if (r_row == r_y1) begin
                    n_out.marked_any = 1'b1;
                    n_out_valid      = 1'b1;
                    n_row            = '0;
                    n_state          = S_IDLE;
                end else begin
                    n_row   = r_row + 18'd1;
                    n_state = S_MRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_cnt       <= '0;
            r_which     <= 1'b0;
            r_out_valid <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sh        <= '0;
            r_org_x     <= RST_ORIGIN_X;
            r_org_y     <= RST_ORIGIN_Y;
            r_mount     <= RST_MOUNT;
            r_scan      <= RST_SCAN_START;
            r_step      <= RST_BEAM_STEP;
            r_rad       <= RST_RADIUS;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_which     <= n_which;
            r_out_valid <= n_out_valid;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_sh        <= n_sh;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_X:   r_org_x <= i_cfg_wdata;
                    CFG_ORIGIN_Y:   r_org_y <= i_cfg_wdata;
                    CFG_MOUNT:      r_mount <= i_cfg_wdata[19:0];
                    CFG_SCAN_START: r_scan  <= i_cfg_wdata;
                    CFG_BEAM_STEP:  r_step  <= i_cfg_wdata[20:0];
                    CFG_RADIUS:     r_rad   <= i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_ang   <= n_ang;
        r_red   <= n_red;
        r_range <= n_range;
        r_z     <= n_z;
        r_neg   <= n_neg;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_hc    <= n_hc;
        r_hs    <= n_hs;
        r_bc    <= n_bc;
        r_bs    <= n_bs;
        r_prod  <= n_prod;
        r_accx  <= n_accx;
        r_accy  <= n_accy;
        r_hcx   <= n_hcx;
        r_hcy   <= n_hcy;
        r_x0    <= n_x0;
        r_x1    <= n_x1;
        r_y0    <= n_y0;
        r_y1    <= n_y1;
        r_qx    <= n_qx;
        r_qok   <= n_qok;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_MWR))
        else $error("grid written outside clear or mark");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MWR) |-> (r_row >= r_y0 && r_row <= r_y1))
        else $error("marked row outside clipped square");

    a_rot_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_cnt <= ROT_LAST))
        else $error("rotation counter overrun");

    a_beam_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.func == FUNC_BEAM && i_item.range_valid
         && ({5'b0, i_item.beam_index} < BEAM_LIM)) |=> (o_busy && !o_valid))
        else $error("valid beam item did not start processing");
`endif

endmodule
